[rtl/core/ffha_pkg.sv]
package ffha_pkg;

  localparam int MAX_BLOCKS_DEF = 64;
  localparam int HEADER_BYTES   = 12;
  localparam int BASE_ALIGN     = 16;   // power of two
  localparam int SIZE_W         = 25;
  localparam int ADDR_W         = 32;
  localparam int NEED_W         = SIZE_W + 2;
  localparam int CFG_IDX_W      = 2;

  localparam logic [SIZE_W-1:0] HEAP_SIZE_RESET = 25'h100_0000;

  typedef enum logic [1:0] {
    STAT_OK         = 2'd0,
    STAT_NO_SPACE   = 2'd1,
    STAT_TABLE_FULL = 2'd2,
    STAT_NOT_FOUND  = 2'd3
  } status_t;

  typedef enum logic {
    REQ_ALLOC = 1'b0,
    REQ_FREE  = 1'b1
  } req_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_HEAP_BASE = 2'd0,
    REG_HEAP_SIZE = 2'd1
  } cfg_reg_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_APPEND
  } state_t;

  typedef struct packed {
    logic [SIZE_W-1:0] offset;
    logic [SIZE_W-1:0] size;
    logic              used;
  } entry_t;

endpackage

[rtl/core/first_fit_heap_allocator_core.sv]
// Sequence: an item is accepted in idle, then the table entries are scanned newest first
//   (entry_count-1 at most, one memory read each), then an allocation that finds no free entry
//   is appended; done pulses in the cycle after the item ends.
// Throughput: one item at a time; start is taken again in the cycle done is shown.
// Reset: rst (synchronous) empties the table to the sentinel and restores the registers.
// The receiver cannot stall; each result is held from done until the next item finishes.
module first_fit_heap_allocator_core
  import ffha_pkg::*;
#(
  parameter int MAX_BLOCKS = MAX_BLOCKS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [ADDR_W-1:0]    cfg_data,
  input  logic                 req_type,
  input  logic [SIZE_W-1:0]    request_size,
  input  logic [ADDR_W-1:0]    free_address,
  output logic                 done,
  output logic [1:0]           status,
  output logic [ADDR_W-1:0]    payload_address,
  output logic                 reused
);

  localparam int AW = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
  localparam int CW = $clog2(MAX_BLOCKS + 1);
  localparam logic [ADDR_W:0]   ALIGN_M  = (ADDR_W + 1)'(BASE_ALIGN - 1);
  localparam logic [ADDR_W-1:0] HDR_A    = ADDR_W'(HEADER_BYTES);
  localparam logic [NEED_W-1:0] HDR_N    = NEED_W'(HEADER_BYTES);
  localparam logic [CW-1:0]     CNT_MAX  = CW'(MAX_BLOCKS);
  localparam logic [CW-1:0]     CNT_ONE  = CW'(1);
  localparam logic [AW-1:0]     IDX_ONE  = AW'(1);

  // configuration
  logic [ADDR_W-1:0] heap_base;
  logic [SIZE_W-1:0] heap_size;
  logic [ADDR_W:0]   abase;
  logic [ADDR_W-1:0] pay_base;
  logic [ADDR_W:0]   limit;
  logic [ADDR_W:0]   abase_w;

  // allocator state
  state_t            state, state_next;
  logic [CW-1:0]     entry_count;
  logic [SIZE_W-1:0] bump_offset;

  // request
  req_t              req_type_r;
  logic [SIZE_W-1:0] req_size;
  logic [ADDR_W-1:0] free_target;
  logic [NEED_W-1:0] need_part;

  // memory
  entry_t            mem [MAX_BLOCKS];
  entry_t            rdata;
  logic [AW-1:0]     rd_addr;
  logic [AW-1:0]     scan_idx;
  logic              mem_we;
  logic [AW-1:0]     mem_wa;
  entry_t            mem_wd;

  // control
  logic              load;
  logic              append;
  logic              fin;
  status_t           fin_status;
  logic [ADDR_W-1:0] fin_addr;
  logic              fin_reused;
  logic              hit;
  logic [CW-1:0]     count_m1;
  logic [ADDR_W+1:0] need;

  status_t           status_r;

  assign abase_w  = ({1'b0, cfg_data} + ALIGN_M) & ~ALIGN_M;
  assign count_m1 = entry_count - CNT_ONE;
  assign need     = {1'b0, abase} + (ADDR_W + 2)'(need_part);
  assign busy     = (state != ST_IDLE);
  assign status   = status_r;

  always_comb begin
    if (req_type_r == REQ_FREE) begin
      hit = ({{(ADDR_W-SIZE_W){1'b0}}, rdata.offset} == free_target);
    end else begin
      hit = !rdata.used && (rdata.size >= req_size);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      heap_base <= '0;
      heap_size <= HEAP_SIZE_RESET;
      abase     <= '0;
      pay_base  <= HDR_A;
      limit     <= (ADDR_W + 1)'(HEAP_SIZE_RESET);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_HEAP_BASE: begin
          heap_base <= cfg_data;
          abase     <= abase_w;
          pay_base  <= abase_w[ADDR_W-1:0] + HDR_A;
          limit     <= {1'b0, cfg_data} + (ADDR_W + 1)'(heap_size);
        end
        REG_HEAP_SIZE: begin
          heap_size <= cfg_data[SIZE_W-1:0];
          limit     <= {1'b0, heap_base} + (ADDR_W + 1)'(cfg_data[SIZE_W-1:0]);
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    state_next = state;
    rd_addr    = scan_idx - IDX_ONE;
    mem_we     = 1'b0;
    mem_wa     = scan_idx;
    mem_wd     = rdata;
    load       = 1'b0;
    append     = 1'b0;
    fin        = 1'b0;
    fin_status = STAT_OK;
    fin_addr   = '0;
    fin_reused = 1'b0;
    unique case (state)
      ST_IDLE: begin
        rd_addr = count_m1[AW-1:0];
        if (start) begin
          load = 1'b1;
          if (entry_count > CNT_ONE) begin
            state_next = ST_SCAN;
          end else if (req_t'(req_type) == REQ_ALLOC) begin
            state_next = ST_APPEND;
          end else begin
            fin        = 1'b1;
            fin_status = STAT_NOT_FOUND;
          end
        end
      end
      ST_SCAN: begin
        if (hit) begin
          mem_we      = 1'b1;
          mem_wd.used = (req_type_r == REQ_ALLOC);
          fin         = 1'b1;
          if (req_type_r == REQ_ALLOC) begin
            fin_addr   = pay_base + ADDR_W'(rdata.offset);
            fin_reused = 1'b1;
          end
          state_next = ST_IDLE;
        end else if (scan_idx == IDX_ONE) begin
          if (req_type_r == REQ_ALLOC) begin
            state_next = ST_APPEND;
          end else begin
            fin        = 1'b1;
            fin_status = STAT_NOT_FOUND;
            state_next = ST_IDLE;
          end
        end
      end
      ST_APPEND: begin
        fin        = 1'b1;
        state_next = ST_IDLE;
        if (need > (ADDR_W + 2)'(limit)) begin
          fin_status = STAT_NO_SPACE;
        end else if (entry_count == CNT_MAX) begin
          fin_status = STAT_TABLE_FULL;
        end else begin
          mem_we        = 1'b1;
          mem_wa        = entry_count[AW-1:0];
          mem_wd.offset = bump_offset;
          mem_wd.size   = req_size;
          mem_wd.used   = 1'b1;
          append        = 1'b1;
          fin_addr      = pay_base + ADDR_W'(bump_offset);
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_count <= CNT_ONE;
      bump_offset <= SIZE_W'(HEADER_BYTES);
      done        <= 1'b0;
    end else begin
      done <= fin;
      if (append) begin
        entry_count <= entry_count + CNT_ONE;
        bump_offset <= need_part[SIZE_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    scan_idx <= rd_addr;
    if (load) begin
      req_type_r  <= req_t'(req_type);
      req_size    <= request_size;
      free_target <= free_address - pay_base;
      need_part   <= NEED_W'(bump_offset) + HDR_N + NEED_W'(request_size);
    end
    if (fin) begin
      status_r        <= fin_status;
      payload_address <= fin_addr;
      reused          <= fin_reused;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    rdata <= mem[rd_addr];
  end

endmodule
